[rtl/core/sensor_window_average_monitor_defines.svh]
// Assertion macros used by the checker file of the window average monitor.
// No dependencies; include by bare file name.
`ifndef SENSOR_WINDOW_AVERAGE_MONITOR_DEFINES_SVH
`define SENSOR_WINDOW_AVERAGE_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SWAM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/swam_pkg.sv]
// Package of the sensor window average monitor: sizes, codes and shared types.
// No dependencies.
package swam_pkg;

  localparam int MAX_SENSORS = 16;
  localparam int WINDOW_LEN  = 5;

  localparam int IDX_W     = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int USED_W    = $clog2(MAX_SENSORS + 1);
  localparam int PTR_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FILL_W    = $clog2(WINDOW_LEN + 1);
  localparam int WIN_DEPTH = MAX_SENSORS * WINDOW_LEN;
  localparam int WADDR_W   = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int SUM_W     = 17 + $clog2(WINDOW_LEN);
  localparam int ALU_W     = SUM_W + 1;
  localparam int DCNT_W    = $clog2(SUM_W);

  localparam int DATA_W    = 16;
  localparam int FILLED_W  = 5;
  localparam int STATUS_W  = 3;

  localparam logic [15:0] COLD_RESET = 16'd2560;
  localparam logic [15:0] HOT_RESET  = 16'd6400;

  // Register index taken from paddr[2].
  localparam logic CFG_COLD = 1'b0;
  localparam logic CFG_HOT  = 1'b1;

  localparam logic FUNC_REGISTER = 1'b0;
  localparam logic FUNC_SAMPLE   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_REGISTERED = 3'd0,
    STAT_FULL       = 3'd1,
    STAT_IN_RANGE   = 3'd2,
    STAT_COLD       = 3'd3,
    STAT_HOT        = 3'd4,
    STAT_UNKNOWN    = 3'd5
  } status_e;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SEARCH = 8'b0000_0010,
    ST_WRITE  = 8'b0000_0100,
    ST_READ   = 8'b0000_1000,
    ST_ABS    = 8'b0001_0000,
    ST_DIV    = 8'b0010_0000,
    ST_SIGN   = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

endpackage

[rtl/core/sensor_window_average_monitor.sv]
// Channel    | dir | handshake                  | payload
// -----------+-----+----------------------------+----------------------------------------
// s_axis     | in  | s_axis_tvalid/tready       | tuser: func; tdata: id, room, sample
// m_axis     | out | m_axis_tvalid/tready       | tuser: status; tdata: room, avg, filled
// apb        | in  | psel, penable, pready = 1  | 0x0 cold_limit, 0x4 hot_limit
//
// In a sample request the id search steps one entry a cycle, the window sum reads
// one sample a cycle from the window memory, and the restoring divider makes one
// quotient bit a cycle; the window sum and the divider share the one adder.
// An unknown id ends the request once the search passes the used entries.
// Reset clears the table count, fill counts and write pointers and loads the
// default limits; no clearing pass runs.
// The input stays not ready from accept until the result is loaded into the output
// register; a result waiting there holds the next request only once its result is ready.
// Top level of the sensor window average monitor.
// Depends on swam_pkg, swam_alu and swam_win_ram.
module sensor_window_average_monitor import swam_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] sid, [31:16] room_number, [47:32] sample
  input  logic [0:0]  s_axis_tuser,   // [0] func
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] room_of_sensor, [31:16] average,
                                      // [36:32] filled, [39:37] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_e state_q;

  // configuration registers
  logic [15:0] cold_q, hot_q;

  // sensor table
  logic [DATA_W-1:0] id_table_q   [MAX_SENSORS];
  logic [DATA_W-1:0] room_table_q [MAX_SENSORS];
  logic [FILL_W-1:0] fill_q       [MAX_SENSORS];
  logic [PTR_W-1:0]  ptr_q        [MAX_SENSORS];
  logic [USED_W-1:0] used_q;

  // request and working registers
  logic [DATA_W-1:0] sid_q, sample_q;
  logic [USED_W-1:0] idx_q;
  logic [IDX_W-1:0]  e_q;
  logic [FILL_W-1:0] n_q, k_q, rem_q;
  logic              rd_pend_q;
  logic [SUM_W-1:0]  acc_q, dvd_q;
  logic              neg_q;
  logic [DCNT_W-1:0] cnt_q;

  // result staging and output register
  status_e           res_status_q, out_status_q;
  logic [DATA_W-1:0] res_room_q, res_avg_q, out_room_q, out_avg_q;
  logic [FILL_W-1:0] res_filled_q, out_filled_q;
  logic              out_valid_q;

  // unpacked input fields
  logic              in_func;
  logic [DATA_W-1:0] in_sid, in_room, in_sample;
  assign in_func   = s_axis_tuser[0];
  assign in_sid    = s_axis_tdata[15:0];
  assign in_room   = s_axis_tdata[31:16];
  assign in_sample = s_axis_tdata[47:32];

  logic in_fire, out_fire, cfg_wr, out_load, table_full;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid_q && m_axis_tready;
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  assign table_full    = (used_q >= USED_W'(MAX_SENSORS));

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {16'b0, (paddr[2] == CFG_HOT) ? hot_q : cold_q};

  // ------------------------------------------------------------------
  // Search, window bookkeeping
  // ------------------------------------------------------------------
  logic              search_miss, search_hit;
  logic [FILL_W-1:0] fill_e, n_new;
  logic [PTR_W-1:0]  ptr_e, ptr_nxt;

  assign search_miss = (idx_q >= used_q);
  assign search_hit  = !search_miss && (id_table_q[idx_q[IDX_W-1:0]] == sid_q);
  assign fill_e      = fill_q[e_q];
  assign ptr_e       = ptr_q[e_q];
  assign n_new       = (fill_e < FILL_W'(WINDOW_LEN)) ? fill_e + FILL_W'(1)
                                                      : FILL_W'(WINDOW_LEN);
  assign ptr_nxt     = (ptr_e == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_e + PTR_W'(1);

  // ------------------------------------------------------------------
  // Window memory
  // ------------------------------------------------------------------
  logic              ram_we;
  logic [WADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  assign ram_we    = (state_q == ST_WRITE);
  assign ram_waddr = WADDR_W'(int'(e_q) * WINDOW_LEN + int'(ptr_e));
  assign ram_raddr = WADDR_W'(int'(e_q) * WINDOW_LEN + int'(k_q));

  swam_win_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (sample_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ------------------------------------------------------------------
  // Shared adder: accumulate, absolute value, divide step, sign restore
  // ------------------------------------------------------------------
  alu_req_t          alu_req;
  logic [ALU_W-1:0]  alu_res;
  logic [FILL_W:0]   rem_shift;

  assign rem_shift = {rem_q, dvd_q[SUM_W-1]};

  always_comb begin
    alu_req = '{op: ALU_ADD, a: '0, b: '0};
    unique case (state_q)
      ST_READ: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = {{(ALU_W-SUM_W){acc_q[SUM_W-1]}}, acc_q};
        alu_req.b  = {{(ALU_W-DATA_W){ram_rdata[DATA_W-1]}}, ram_rdata};
      end
      ST_ABS: begin
        alu_req.op = ALU_SUB;
        alu_req.b  = {{(ALU_W-SUM_W){acc_q[SUM_W-1]}}, acc_q};
      end
      ST_DIV: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(rem_shift);
        alu_req.b  = ALU_W'(n_q);
      end
      ST_SIGN: begin
        alu_req.op = ALU_SUB;
        alu_req.b  = ALU_W'(dvd_q);
      end
      default: ;
    endcase
  end

  swam_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  logic              div_take;
  logic [DATA_W-1:0] avg_final;
  assign div_take  = !alu_res[ALU_W-1];
  assign avg_final = neg_q ? alu_res[DATA_W-1:0] : dvd_q[DATA_W-1:0];

  // ------------------------------------------------------------------
  // Control state
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cold_q      <= COLD_RESET;
      hot_q       <= HOT_RESET;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
      for (int i = 0; i < MAX_SENSORS; i++) begin
        fill_q[i] <= '0;
        ptr_q[i]  <= '0;
      end
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == CFG_COLD) cold_q <= pwdata[15:0];
        else                      hot_q  <= pwdata[15:0];
      end

      if (out_load)      out_valid_q <= 1'b1;
      else if (out_fire) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_func == FUNC_SAMPLE) begin
              state_q <= ST_SEARCH;
            end else begin
              // append a new entry unless the table is full
              if (!table_full) begin
                fill_q[used_q[IDX_W-1:0]] <= '0;
                ptr_q[used_q[IDX_W-1:0]]  <= '0;
                used_q                    <= used_q + USED_W'(1);
              end
              state_q <= ST_DONE;
            end
          end
        end
        ST_SEARCH: begin
          if (search_miss)     state_q <= ST_DONE;
          else if (search_hit) state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          fill_q[e_q] <= n_new;
          ptr_q[e_q]  <= ptr_nxt;
          rd_pend_q   <= 1'b0;
          state_q     <= ST_READ;
        end
        ST_READ: begin
          rd_pend_q <= (k_q < n_q);
          if (k_q == n_q && !rd_pend_q) state_q <= ST_ABS;
        end
        ST_ABS:  state_q <= ST_DIV;
        ST_DIV: begin
          if (cnt_q == DCNT_W'(SUM_W - 1)) state_q <= ST_SIGN;
        end
        ST_SIGN: state_q <= ST_DONE;
        ST_DONE: begin
          if (out_load) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Payload registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_room_q   <= res_room_q;
      out_avg_q    <= res_avg_q;
      out_filled_q <= res_filled_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          sid_q        <= in_sid;
          sample_q     <= in_sample;
          idx_q        <= '0;
          res_room_q   <= '0;
          res_avg_q    <= '0;
          res_filled_q <= '0;
          res_status_q <= table_full ? STAT_FULL : STAT_REGISTERED;
          if (in_func == FUNC_REGISTER && !table_full) begin
            id_table_q[used_q[IDX_W-1:0]]   <= in_sid;
            room_table_q[used_q[IDX_W-1:0]] <= in_room;
          end
        end
      end
      ST_SEARCH: begin
        if (search_miss) begin
          res_status_q <= STAT_UNKNOWN;
        end else if (search_hit) begin
          e_q <= idx_q[IDX_W-1:0];
        end else begin
          idx_q <= idx_q + USED_W'(1);
        end
      end
      ST_WRITE: begin
        n_q        <= n_new;
        k_q        <= '0;
        acc_q      <= '0;
        res_room_q <= room_table_q[e_q];
      end
      ST_READ: begin
        if (k_q < n_q) k_q <= k_q + FILL_W'(1);
        if (rd_pend_q) acc_q <= alu_res[SUM_W-1:0];
      end
      ST_ABS: begin
        // divide the magnitude, restore the sign afterwards
        neg_q <= acc_q[SUM_W-1];
        dvd_q <= acc_q[SUM_W-1] ? alu_res[SUM_W-1:0] : acc_q;
        rem_q <= '0;
        cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q <= div_take ? alu_res[FILL_W-1:0] : rem_shift[FILL_W-1:0];
        dvd_q <= {dvd_q[SUM_W-2:0], div_take};
        cnt_q <= cnt_q + DCNT_W'(1);
      end
      ST_SIGN: begin
        res_avg_q    <= avg_final;
        res_filled_q <= n_q;
        if ($signed(avg_final) > $signed(hot_q))       res_status_q <= STAT_HOT;
        else if ($signed(avg_final) < $signed(cold_q)) res_status_q <= STAT_COLD;
        else                                           res_status_q <= STAT_IN_RANGE;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {3'b000, FILLED_W'(out_filled_q), out_avg_q, out_room_q};

endmodule

[rtl/core/swam_alu.sv]
// Shared add/subtract unit of the window average monitor.
// Depends on swam_pkg.
module swam_alu import swam_pkg::*; (
  input  alu_req_t         req_i,
  output logic [ALU_W-1:0] res_o
);

  always_comb begin
    unique case (req_i.op)
      ALU_ADD: res_o = req_i.a + req_i.b;
      ALU_SUB: res_o = req_i.a - req_i.b;
      default: res_o = '0;
    endcase
  end

endmodule

[rtl/core/swam_win_ram.sv]
// Sample window memory: one write port, one registered read port.
// Depends on swam_pkg.
module swam_win_ram import swam_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [WADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0]  wdata_i,
  input  logic [WADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0]  rdata_o
);

  logic [DATA_W-1:0] mem_q [WIN_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/swam_checker.sv]
// Port-level checker of the window average monitor, bound to the top level.
// Depends on swam_pkg and sensor_window_average_monitor_defines.svh.
`include "sensor_window_average_monitor_defines.svh"

module swam_checker import swam_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  logic is_sample_result, is_plain_result;
  assign is_sample_result = (m_axis_tuser == STAT_IN_RANGE) || (m_axis_tuser == STAT_COLD) ||
                            (m_axis_tuser == STAT_HOT);
  assign is_plain_result  = (m_axis_tuser == STAT_REGISTERED) ||
                            (m_axis_tuser == STAT_FULL) || (m_axis_tuser == STAT_UNKNOWN);

  `SWAM_ASSERT_NOW(a_status_known, m_axis_tvalid, is_sample_result || is_plain_result, "bad status")
  `SWAM_ASSERT_NOW(a_plain_zero, m_axis_tvalid && is_plain_result, m_axis_tdata == 40'd0, "nonzero fields")
  `SWAM_ASSERT_NOW(a_fill_range, m_axis_tvalid && is_sample_result, (m_axis_tdata[36:32] != 5'd0) && (m_axis_tdata[36:32] <= 5'(WINDOW_LEN)) && (m_axis_tdata[39:37] == 3'd0), "fill count out of range")
  `SWAM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result dropped while stalled")

endmodule

bind sensor_window_average_monitor swam_checker u_swam_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[dv/tb_top.sv]
// Self-checking testbench of the sensor window average monitor.
// Depends on swam_pkg and the sensor_window_average_monitor RTL; needs nothing else.
module tb_top;
  import swam_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  // Longest sample request: full search, full window, divider and wrap-up.
  localparam int DRAIN_CYCLES = 64;
  localparam int ITEMS_PER_PHASE = 330;

  typedef struct {
    status_e            status;
    logic [15:0]        room;
    logic signed [15:0] average;
    logic [4:0]         filled;
  } window_result_t;

  // Scoreboard: mirrors the sensor table and the window averages, queues
  // the expected results and compares each returned result against them.
  class window_scoreboard;
    logic [15:0]        id_tab[MAX_SENSORS];
    logic [15:0]        room_tab[MAX_SENSORS];
    logic signed [15:0] win[MAX_SENSORS][WINDOW_LEN];
    int                 fill[MAX_SENSORS] = '{default: 0};
    int                 used = 0;
    logic signed [15:0] cold = COLD_RESET;
    logic signed [15:0] hot  = HOT_RESET;
    window_result_t     pending[$];
    int                 mismatches = 0;

    function int lookup(logic [15:0] id);
      for (int e = 0; e < used; e++) begin
        if (id_tab[e] == id) return e;
      end
      return -1;
    endfunction

    function void set_limit(logic idx, logic [15:0] value);
      if (idx == CFG_COLD) cold = value;
      else hot = value;
    endfunction

    // Update the mirror with one accepted request and queue its result.
    function void note_request(logic func, logic [15:0] id, logic [15:0] room,
                               logic signed [15:0] smp);
      window_result_t r;
      int e;
      int sum;
      int mean;
      r.status  = STAT_REGISTERED;
      r.room    = '0;
      r.average = '0;
      r.filled  = '0;
      e = lookup(id);
      if (func == FUNC_REGISTER) begin
        if (used >= MAX_SENSORS) begin
          r.status = STAT_FULL;
        end else begin
          id_tab[used]   = id;
          room_tab[used] = room;
          fill[used]     = 0;
          used++;
        end
      end else if (e < 0) begin
        r.status = STAT_UNKNOWN;
      end else begin
        if (fill[e] < WINDOW_LEN) begin
          win[e][fill[e]] = smp;
          fill[e]++;
        end else begin
          for (int k = 0; k + 1 < WINDOW_LEN; k++) win[e][k] = win[e][k+1];
          win[e][WINDOW_LEN-1] = smp;
        end
        sum = 0;
        for (int k = 0; k < fill[e]; k++) sum += win[e][k];
        mean = sum / fill[e];
        if (mean > hot) r.status = STAT_HOT;
        else if (mean < cold) r.status = STAT_COLD;
        else r.status = STAT_IN_RANGE;
        r.room    = room_tab[e];
        r.average = 16'(mean);
        r.filled  = 5'(fill[e]);
      end
      pending.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [2:0] status, logic [15:0] room,
                      logic signed [15:0] average, logic [4:0] filled);
      window_result_t exp_r;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result with none outstanding: status %0d room %h",
                                  status, room));
      end else begin
        exp_r = pending.pop_front();
        if (status !== exp_r.status)
          report_mismatch($sformatf("status %0d, want %0d", status, exp_r.status));
        if (room !== exp_r.room)
          report_mismatch($sformatf("room %h, want %h", room, exp_r.room));
        if (average !== exp_r.average)
          report_mismatch($sformatf("average %0d, want %0d", average, exp_r.average));
        if (filled !== exp_r.filled)
          report_mismatch($sformatf("filled %0d, want %0d", filled, exp_r.filled));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // [15:0] sid, [31:16] room_number, [47:32] sample
  logic [0:0]  s_axis_tuser;   // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [15:0] room_of_sensor, [31:16] average, [36:32] filled
  logic [2:0]  m_axis_tuser;   // [2:0] status
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  window_scoreboard sb = new;
  int  cycle_count  = 0;
  int  sent_count   = 0;
  bit  sender_quiet = 1'b0;

  sensor_window_average_monitor i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock, and a single reset pulse at the start of the run.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sensor_window_average_monitor test failed");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it. Lower tvalid
  // only when a gap follows, so it is never dropped and raised in one step.
  task automatic send_request(logic func, logic [15:0] id, logic [15:0] room,
                              logic [15:0] smp);
    int gap;
    if (sent_count % 64 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
    gap = sender_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {smp, room, id};
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(func, id, room, smp);
    sent_count++;
  endtask

  // Drop tvalid and hold off until every outstanding result is back and
  // the block has had time to settle.
  task automatic drain_requests();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one limit, then read it back in the following transfer.
  task automatic write_limit(logic idx, logic [15:0] value);
    paddr   <= {idx, 2'b00};
    pwdata  <= {{16{value[15]}}, value};
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_limit(idx, value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== value)
      sb.report_mismatch($sformatf("limit %0d reads %h, want %h", idx, prdata[15:0], value));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sample value close to a limit, clamped to the Q8.8 range.
  function automatic logic [15:0] near_limit(logic signed [15:0] lim);
    int v;
    v = int'(lim) + int'($urandom_range(0, 4000)) - 2000;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // Mostly samples to registered sensors; some unknown ids and registrations.
  task automatic random_request();
    int pick;
    int roll;
    logic [15:0] id;
    logic [15:0] smp;
    pick = $urandom_range(0, 99);
    roll = $urandom_range(0, 9);
    if (roll < 2) smp = 16'($urandom);
    else if (roll < 6) smp = near_limit(sb.cold);
    else smp = near_limit(sb.hot);
    if (pick < 10) begin
      // reuse an existing id now and then to build duplicates
      if (pick < 3) id = sb.id_tab[$urandom_range(0, sb.used - 1)];
      else id = 16'($urandom);
      send_request(FUNC_REGISTER, id, 16'($urandom), smp);
    end else if (pick < 20) begin
      id = 16'($urandom);
      while (sb.lookup(id) >= 0) id++;
      send_request(FUNC_SAMPLE, id, 16'($urandom), smp);
    end else begin
      id = sb.id_tab[$urandom_range(0, sb.used - 1)];
      send_request(FUNC_SAMPLE, id, 16'($urandom), smp);
    end
  endtask

  // Result side: stall at random, with quiet stretches, and check each result.
  initial begin : result_sink
    int stall;
    int taken;
    bit quiet;
    m_axis_tready <= 1'b0;
    taken = 0;
    quiet = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      stall = quiet ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                      m_axis_tdata[36:32]);
      taken++;
    end
  end

  // Stimulus: directed corner cases and a random phase under reset limits, then
  // further random phases, each behind a limit change made while the block is idle.
  initial begin : stimulus
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: begin
          write_limit(CFG_COLD, 16'h8000);
          write_limit(CFG_HOT, 16'h7FFF);
        end
        2: begin
          // crossed limits: too hot takes priority
          write_limit(CFG_COLD, 16'h7FFF);
          write_limit(CFG_HOT, 16'h8000);
        end
        3: begin
          write_limit(CFG_COLD, 16'h0000);
          write_limit(CFG_HOT, 16'h0000);
        end
        4: begin
          write_limit(CFG_COLD, 16'($urandom));
          write_limit(CFG_HOT, 16'($urandom));
        end
        5: begin
          write_limit(CFG_COLD, COLD_RESET);
          write_limit(CFG_HOT, HOT_RESET);
        end
        default: ;
      endcase
      if (phase == 0) begin
        // unknown sensor while the table is still empty
        send_request(FUNC_SAMPLE, 16'h0005, 16'h0000, 16'h0100);
        send_request(FUNC_REGISTER, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_request(FUNC_REGISTER, 16'hFFFF, 16'h0000, 16'h8000);
        send_request(FUNC_REGISTER, 16'h1234, 16'hABCD, 16'h0000);
        // duplicate id: samples keep going to the first entry
        send_request(FUNC_REGISTER, 16'h1234, 16'h5555, 16'h0000);
        // fill the window with extremes and shift one out
        repeat (6) send_request(FUNC_SAMPLE, 16'h0000, 16'h1111, 16'h7FFF);
        repeat (6) send_request(FUNC_SAMPLE, 16'hFFFF, 16'h2222, 16'h8000);
        // mean equal to the cold limit, then a negative mean truncated toward zero
        send_request(FUNC_SAMPLE, 16'h1234, 16'h5555, 16'd2560);
        send_request(FUNC_SAMPLE, 16'h1234, 16'h0000, 16'd6400);
        send_request(FUNC_SAMPLE, 16'h1234, 16'h0000, -16'sd9000);
        // mean on the hot limit, then one step above it
        send_request(FUNC_REGISTER, 16'h00AA, 16'h0A0A, 16'h0000);
        send_request(FUNC_SAMPLE, 16'h00AA, 16'h0000, 16'd6400);
        send_request(FUNC_SAMPLE, 16'h00AA, 16'h0000, 16'd6402);
        // one step below the cold limit
        send_request(FUNC_REGISTER, 16'h00BB, 16'h0B0B, 16'h0000);
        send_request(FUNC_SAMPLE, 16'h00BB, 16'h0000, 16'd2559);
      end
      repeat (ITEMS_PER_PHASE) random_request();
      // hold off the sender until every result of the phase is back
      drain_requests();
    end
    if (sb.mismatches == 0) begin
      $display("sensor_window_average_monitor test passed");
    end else begin
      $display("sensor_window_average_monitor test failed");
    end
    $finish;
  end

endmodule
